// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Every check is sampled on the rising edge of clock and is held off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define NR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define NR_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/nrep_pkg.sv =====
// ----------------------------------------------------------------------------
// nrep_pkg
// Shared types and constants for the neighbor report element parser.
// ----------------------------------------------------------------------------
package nrep_pkg;

   localparam int LENGTH_BITS_DEF = 12;
   localparam int REPORT_LEN_W    = 12;
   localparam int BSSID_W         = 48;
   localparam int INFO_W          = 32;
   localparam int RSP_FIFO_DEPTH  = 4;

   // Element layout.
   localparam logic [7:0] NR_ID          = 8'd52;
   localparam int         BSSID_BYTES    = 6;
   localparam int         NR_FIXED_LEN   = BSSID_BYTES + 4 + 1 + 1 + 1;
   localparam int         NR_MIN_REMAIN  = 2 + NR_FIXED_LEN;
   localparam logic [3:0] IDX_INFO_END   = 4'(BSSID_BYTES + 4);
   localparam logic [3:0] IDX_CLASS      = 4'(BSSID_BYTES + 4);
   localparam logic [3:0] IDX_CHANNEL    = 4'(BSSID_BYTES + 5);
   localparam logic [3:0] IDX_LAST_FIXED = 4'(NR_FIXED_LEN - 1);
   localparam logic [3:0] IDX_BSSID_END  = 4'(BSSID_BYTES);

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_DATA  = 1'b1;

   typedef enum logic [1:0] {
      KIND_RECORD  = 2'd0,
      KIND_END_OK  = 2'd1,
      KIND_INVALID = 2'd2,
      KIND_EMPTY   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [BSSID_W-1:0]   bssid;
      logic [INFO_W-1:0]    bssid_info;
      logic [7:0]           operating_class;
      logic [7:0]           channel_number;
      logic [7:0]           phy_kind;
      logic                 last_of_run;
   } result_type;

   // Up to two results leave the parser for one input transaction.
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

endpackage

// ===== rtl/nrep_parse.sv =====
// ----------------------------------------------------------------------------
// nrep_parse
// Byte-wise parse state machine: consumes one registered input transaction
// per step and produces zero, one or two results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nrep_parse
   import nrep_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    mode,
   input  logic [7:0]              data_byte,
   input  logic [REPORT_LEN_W-1:0] report_length,
   output push_type                push
);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_HEAD_ID  = 3'd1,
      PH_HEAD_LEN = 3'd2,
      PH_FIXED    = 3'd3,
      PH_SUB_ID   = 3'd4,
      PH_SUB_LEN  = 3'd5,
      PH_SUB_BODY = 3'd6,
      PH_SKIP     = 3'd7
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] rbl_ff, rbl_in;
   logic [7:0]             ebl_ff, ebl_in;
   logic [3:0]             idx_ff, idx_in;
   logic [7:0]             sbl_ff, sbl_in;
   logic [BSSID_W-1:0]     bssid_ff, bssid_in;
   logic [INFO_W-1:0]      info_ff, info_in;
   logic [7:0]             class_ff, class_in;
   logic [7:0]             chan_ff, chan_in;

   logic [LENGTH_BITS-1:0] rbl_dec, start_len;
   logic [7:0]             ebl_dec, sbl_dec;
   logic                   elem_bnd, sub_bnd, emit_rec, emit_stat;
   kind_type               stat_kind;
   result_type             rec_res, stat_res;

   assign rbl_dec   = (rbl_ff != '0) ? rbl_ff - 1'b1 : rbl_ff;
   assign ebl_dec   = (ebl_ff != 8'd0) ? ebl_ff - 8'd1 : ebl_ff;
   assign sbl_dec   = (sbl_ff != 8'd0) ? sbl_ff - 8'd1 : sbl_ff;
   assign start_len = LENGTH_BITS'(report_length);

   always_comb begin
      phase_in  = phase_ff;
      rbl_in    = rbl_ff;
      ebl_in    = ebl_ff;
      idx_in    = idx_ff;
      sbl_in    = sbl_ff;
      bssid_in  = bssid_ff;
      info_in   = info_ff;
      class_in  = class_ff;
      chan_in   = chan_ff;
      elem_bnd  = 1'b0;
      sub_bnd   = 1'b0;
      emit_rec  = 1'b0;
      emit_stat = 1'b0;
      stat_kind = KIND_INVALID;

      if (mode == MODE_START) begin
         if (start_len == '0) begin
            phase_in  = PH_IDLE;
            rbl_in    = '0;
            emit_stat = 1'b1;
            stat_kind = KIND_EMPTY;
         end else begin
            rbl_in   = start_len;
            elem_bnd = 1'b1;
         end
      end else if (phase_ff != PH_IDLE) begin
         rbl_in = rbl_dec;
         unique case (phase_ff)
            PH_HEAD_ID: begin
               if (data_byte != NR_ID) begin
                  emit_stat = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  phase_in = PH_HEAD_LEN;
               end
            end
            PH_HEAD_LEN: begin
               if (data_byte < 8'(NR_FIXED_LEN) || LENGTH_BITS'(data_byte) > rbl_dec) begin
                  emit_stat = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  ebl_in   = data_byte;
                  idx_in   = 4'd0;
                  phase_in = PH_FIXED;
               end
            end
            PH_FIXED: begin
               ebl_in = ebl_dec;
               if (idx_ff < IDX_BSSID_END) begin
                  bssid_in = {bssid_ff[BSSID_W-9:0], data_byte};
               end else if (idx_ff < IDX_INFO_END) begin
                  info_in = {data_byte, info_ff[INFO_W-1:8]};
               end else if (idx_ff == IDX_CLASS) begin
                  class_in = data_byte;
               end else if (idx_ff == IDX_CHANNEL) begin
                  chan_in = data_byte;
               end
               if (idx_ff >= IDX_LAST_FIXED) begin
                  emit_rec = 1'b1;
                  idx_in   = 4'd0;
                  sub_bnd  = 1'b1;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            PH_SUB_ID: begin
               ebl_in   = ebl_dec;
               phase_in = PH_SUB_LEN;
            end
            PH_SUB_LEN: begin
               ebl_in = ebl_dec;
               if (data_byte > ebl_dec) begin
                  emit_stat = 1'b1;
                  phase_in  = PH_IDLE;
               end else begin
                  sbl_in = data_byte;
                  if (data_byte == 8'd0) begin
                     sub_bnd = 1'b1;
                  end else begin
                     phase_in = PH_SUB_BODY;
                  end
               end
            end
            PH_SUB_BODY: begin
               ebl_in = ebl_dec;
               sbl_in = sbl_dec;
               if (sbl_dec == 8'd0) begin
                  sub_bnd = 1'b1;
               end
            end
            PH_SKIP: begin
               ebl_in = ebl_dec;
               if (ebl_dec == 8'd0) begin
                  elem_bnd = 1'b1;
               end
            end
            PH_IDLE: begin
            end
         endcase
      end

      // A finished subelement either opens another one, closes the element,
      // or leaves one or two stray bytes to drop.
      if (sub_bnd) begin
         if (ebl_in > 8'd2) begin
            phase_in = PH_SUB_ID;
         end else if (ebl_in == 8'd0) begin
            elem_bnd = 1'b1;
         end else begin
            phase_in = PH_SKIP;
         end
      end

      // At an element boundary a tail too short for an element is skipped.
      if (elem_bnd) begin
         if (rbl_in == '0) begin
            emit_stat = 1'b1;
            stat_kind = KIND_END_OK;
            phase_in  = PH_IDLE;
         end else if (rbl_in >= LENGTH_BITS'(NR_MIN_REMAIN)) begin
            phase_in = PH_HEAD_ID;
         end else begin
            ebl_in   = 8'(rbl_in);
            phase_in = PH_SKIP;
         end
      end
   end

   always_comb begin
      rec_res                 = '0;
      rec_res.kind            = KIND_RECORD;
      rec_res.bssid           = bssid_ff;
      rec_res.bssid_info      = info_ff;
      rec_res.operating_class = class_ff;
      rec_res.channel_number  = chan_ff;
      rec_res.phy_kind        = data_byte;
      rec_res.last_of_run     = !emit_stat;

      stat_res             = '0;
      stat_res.kind        = stat_kind;
      stat_res.last_of_run = 1'b1;

      push = '0;
      if (step) begin
         if (emit_rec) begin
            push.first = rec_res;
            if (emit_stat) begin
               push.second = stat_res;
               push.count  = 2'd2;
            end else begin
               push.count = 2'd1;
            end
         end else if (emit_stat) begin
            push.first = stat_res;
            push.count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rbl_ff   <= '0;
         ebl_ff   <= '0;
         idx_ff   <= '0;
         sbl_ff   <= '0;
         bssid_ff <= '0;
         info_ff  <= '0;
         class_ff <= '0;
         chan_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         rbl_ff   <= rbl_in;
         ebl_ff   <= ebl_in;
         idx_ff   <= idx_in;
         sbl_ff   <= sbl_in;
         bssid_ff <= bssid_in;
         info_ff  <= info_in;
         class_ff <= class_in;
         chan_ff  <= chan_in;
      end
   end

   `NR_ASSERT(a_pair_is_record_then_end,
      push.count == 2'd2 |-> (push.first.kind == KIND_RECORD && push.second.kind == KIND_END_OK),
      "two results must be a record followed by report end")
   `NR_ASSERT(a_idle_data_silent,
      (step && mode == MODE_DATA && phase_ff == PH_IDLE) |-> push.count == 2'd0,
      "data byte while idle must produce no result")

endmodule

// ===== rtl/nrep_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// nrep_rsp_fifo
// Small result queue: takes up to two results per cycle, hands out one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nrep_rsp_fifo
   import nrep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room_for_two,
   output logic       head_valid,
   output result_type head,
   input  logic       pop
);

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   result_type       mem_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;

   assign wr_ptr_next  = wr_ptr_ff + PTR_W'(1);
   assign room_for_two = count_ff <= CNT_W'(RSP_FIFO_DEPTH - 2);
   assign head_valid   = count_ff != '0;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   `NR_ASSERT(a_push_has_room,
      push.count != 2'd0 |-> room_for_two,
      "results pushed without room in the queue")
   `NR_ASSERT_NEVER(a_no_underflow, pop && !head_valid, "pop from an empty queue")

endmodule

// ===== rtl/neighbor_report_element_parser_core.sv =====
// ----------------------------------------------------------------------------
// neighbor_report_element_parser_core
// Streaming 802.11k neighbor report parser: one report byte per transaction
// in, neighbor records and report status out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   mode, data_byte, report_length
// rsp_      out        rsp_valid/rsp_stall   kind, bssid, bssid_info, class, channel, phy
//
// One input transaction per cycle is accepted while the input does not stall;
// the parse step takes it from the input register into the result queue.
// A byte that completes both a record and the report yields two results, so
// the result channel carries two transactions for that byte.
// The input stalls only while the four-entry result queue cannot take two.
// Synchronous reset puts the parser idle with an empty queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module neighbor_report_element_parser_core
   import nrep_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [7:0]              req_data_byte,
   input  logic [REPORT_LEN_W-1:0] req_report_length,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [BSSID_W-1:0]      rsp_bssid,
   output logic [INFO_W-1:0]       rsp_bssid_info,
   output logic [7:0]              rsp_operating_class,
   output logic [7:0]              rsp_channel_number,
   output logic [7:0]              rsp_phy_kind,
   output logic                    rsp_last_of_run
);

   logic                    in_valid_ff, in_valid_in;
   logic                    in_mode_ff;
   logic [7:0]              in_byte_ff;
   logic [REPORT_LEN_W-1:0] in_len_ff;
   logic                    step, accept, room_for_two, pop;
   push_type                push;
   result_type              head;

   assign step      = in_valid_ff && room_for_two;
   assign req_stall = in_valid_ff && !room_for_two;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_data_byte;
         in_len_ff  <= req_report_length;
      end
   end

   nrep_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .mode          (in_mode_ff),
      .data_byte     (in_byte_ff),
      .report_length (in_len_ff),
      .push          (push)
   );

   nrep_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .head_valid   (rsp_valid),
      .head         (head),
      .pop          (pop)
   );

   assign rsp_kind            = head.kind;
   assign rsp_bssid           = head.bssid;
   assign rsp_bssid_info      = head.bssid_info;
   assign rsp_operating_class = head.operating_class;
   assign rsp_channel_number  = head.channel_number;
   assign rsp_phy_kind        = head.phy_kind;
   assign rsp_last_of_run     = head.last_of_run;

   `NR_ASSERT(a_held_item_kept,
      (in_valid_ff && !step) |=> in_valid_ff,
      "a waiting input transaction was dropped")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: neighbor report element parser
// Streams directed and random 802.11k neighbor reports into the parser, one
// byte per transaction. A local model predicts the records and report status
// words, and every result is checked field by field, in order. The phases run
// free, with sender gaps, with receiver stalls or with both. A final phase holds
// the result channel off for a long stretch so that the input must stall.
// ----------------------------------------------------------------------------
module tb
   import nrep_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 16;

   typedef enum logic [2:0] {
      P_IDLE, P_ELEM_ID, P_ELEM_LEN, P_FIXED, P_SUB_ID, P_SUB_LEN, P_SUB_BODY, P_SKIP
   } phase_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = MODE_START;
   logic [7:0]              req_data_byte = 8'd0;
   logic [REPORT_LEN_W-1:0] req_report_length = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_kind;
   logic [BSSID_W-1:0]      rsp_bssid;
   logic [INFO_W-1:0]       rsp_bssid_info;
   logic [7:0]              rsp_operating_class;
   logic [7:0]              rsp_channel_number;
   logic [7:0]              rsp_phy_kind;
   logic                    rsp_last_of_run;

   // Parser model state.
   phase_type               m_phase = P_IDLE;
   logic [REPORT_LEN_W-1:0] m_left = '0;
   logic [7:0]              m_elem_left = '0;
   logic [3:0]              m_fixed_idx = '0;
   logic [7:0]              m_sub_left = '0;
   logic [BSSID_W-1:0]      m_bssid = '0;
   logic [INFO_W-1:0]       m_info = '0;
   logic [7:0]              m_class = '0;
   logic [7:0]              m_channel = '0;

   result_type fresh[$];
   result_type pending_results[$];

   int sender_idle_pct = 0;
   int stall_pct = 0;
   logic pressure_on = 1'b0;
   int hold_count = 0;
   int quiet_cycles = 0;
   int fail_count = 0;
   int items_sent = 0;
   int working_items = 0;
   int records_checked = 0;
   int statuses_checked = 0;

   neighbor_report_element_parser_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_data_byte       (req_data_byte),
      .req_report_length   (req_report_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_bssid           (rsp_bssid),
      .rsp_bssid_info      (rsp_bssid_info),
      .rsp_operating_class (rsp_operating_class),
      .rsp_channel_number  (rsp_channel_number),
      .rsp_phy_kind        (rsp_phy_kind),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic result_type status_of(kind_type k);
      result_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   function automatic void element_done();
      if (m_left == 0) begin
         fresh.push_back(status_of(KIND_END_OK));
         m_phase = P_IDLE;
      end else if (m_left >= NR_MIN_REMAIN) begin
         m_phase = P_ELEM_ID;
      end else begin
         // A tail too short for an element is skipped byte by byte.
         m_elem_left = m_left[7:0];
         m_phase = P_SKIP;
      end
   endfunction

   function automatic void subelement_done();
      if (m_elem_left > 2) m_phase = P_SUB_ID;
      else if (m_elem_left == 0) element_done();
      else m_phase = P_SKIP;
   endfunction

   function automatic void reject();
      fresh.push_back(status_of(KIND_INVALID));
      m_phase = P_IDLE;
   endfunction

   function automatic void parse_step(logic mode, logic [7:0] b,
                                      logic [REPORT_LEN_W-1:0] len);
      result_type rec;
      logic [REPORT_LEN_W-1:0] rlen;
      fresh.delete();
      rlen = len & REPORT_LEN_W'((1 << LENGTH_BITS_DEF) - 1);
      if (mode == MODE_START) begin
         working_items++;
         if (rlen == 0) begin
            m_phase = P_IDLE;
            m_left = '0;
            fresh.push_back(status_of(KIND_EMPTY));
         end else begin
            m_left = rlen;
            element_done();
         end
      end else if (m_phase != P_IDLE) begin
         working_items++;
         if (m_left > 0) m_left--;
         case (m_phase)
            P_ELEM_ID: begin
               if (b != NR_ID) reject();
               else m_phase = P_ELEM_LEN;
            end
            P_ELEM_LEN: begin
               if (b < NR_FIXED_LEN || b > m_left) begin
                  reject();
               end else begin
                  m_elem_left = b;
                  m_fixed_idx = '0;
                  m_phase = P_FIXED;
               end
            end
            P_FIXED: begin
               if (m_elem_left > 0) m_elem_left--;
               if (m_fixed_idx < IDX_BSSID_END) m_bssid = {m_bssid[BSSID_W-9:0], b};
               else if (m_fixed_idx < IDX_INFO_END) m_info = {b, m_info[INFO_W-1:8]};
               else if (m_fixed_idx == IDX_CLASS) m_class = b;
               else if (m_fixed_idx == IDX_CHANNEL) m_channel = b;
               if (m_fixed_idx >= IDX_LAST_FIXED) begin
                  rec = status_of(KIND_RECORD);
                  rec.bssid = m_bssid;
                  rec.bssid_info = m_info;
                  rec.operating_class = m_class;
                  rec.channel_number = m_channel;
                  rec.phy_kind = b;
                  fresh.push_back(rec);
                  m_fixed_idx = '0;
                  subelement_done();
               end else begin
                  m_fixed_idx = m_fixed_idx + 4'd1;
               end
            end
            P_SUB_ID: begin
               if (m_elem_left > 0) m_elem_left--;
               m_phase = P_SUB_LEN;
            end
            P_SUB_LEN: begin
               if (m_elem_left > 0) m_elem_left--;
               if (b > m_elem_left) begin
                  reject();
               end else begin
                  m_sub_left = b;
                  if (b == 0) subelement_done();
                  else m_phase = P_SUB_BODY;
               end
            end
            P_SUB_BODY: begin
               if (m_elem_left > 0) m_elem_left--;
               if (m_sub_left > 0) m_sub_left--;
               if (m_sub_left == 0) subelement_done();
            end
            default: begin
               if (m_elem_left > 0) m_elem_left--;
               if (m_elem_left == 0) element_done();
            end
         endcase
      end
      if (fresh.size() > 0) begin
         fresh[fresh.size()-1].last_of_run = 1'b1;
         foreach (fresh[i]) pending_results.push_back(fresh[i]);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: random stalls, or one long hold-off while pressure is on.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (pressure_on && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
      if (!pressure_on) hold_count <= 0;
   end

   // ------------------------------------------------------------------------
   // Prediction on accepted inputs and in-order checking of results.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_results
      result_type got;
      result_type want;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            parse_step(req_mode, req_data_byte, req_report_length);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got.kind = kind_type'(rsp_kind);
            got.bssid = rsp_bssid;
            got.bssid_info = rsp_bssid_info;
            got.operating_class = rsp_operating_class;
            got.channel_number = rsp_channel_number;
            got.phy_kind = rsp_phy_kind;
            got.last_of_run = rsp_last_of_run;
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("tb: unexpected result, kind %0d bssid %h", rsp_kind, rsp_bssid);
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind || got.bssid !== want.bssid ||
                   got.bssid_info !== want.bssid_info ||
                   got.operating_class !== want.operating_class ||
                   got.channel_number !== want.channel_number ||
                   got.phy_kind !== want.phy_kind ||
                   got.last_of_run !== want.last_of_run) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("tb: mismatch at %0t", $realtime);
                     $display("  expected kind %0d bssid %h info %h cls %h ch %h phy %h last %b",
                              want.kind, want.bssid, want.bssid_info, want.operating_class,
                              want.channel_number, want.phy_kind, want.last_of_run);
                     $display("  actual   kind %0d bssid %h info %h cls %h ch %h phy %h last %b",
                              got.kind, got.bssid, got.bssid_info, got.operating_class,
                              got.channel_number, got.phy_kind, got.last_of_run);
                  end
               end else if (got.kind == KIND_RECORD) begin
                  records_checked++;
               end else begin
                  statuses_checked++;
               end
            end
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb: no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   task automatic send_item(input logic mode, input logic [7:0] b,
                            input logic [REPORT_LEN_W-1:0] len);
      req_mode <= mode;
      req_data_byte <= b;
      req_report_length <= len;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall_in);
      sender_idle_pct = send_pct;
      stall_pct <= stall_in;
   endtask

   // Builds one report, mostly well formed, and streams it. Some reports get a
   // corrupted byte, an overrunning subelement, a wrong declared length, an
   // early cut (abandoned by the next start) or trailing noise bytes.
   task automatic send_report();
      logic [7:0] rpt[$];
      logic [7:0] elem[$];
      int flavor, n_elem, n_sub, sub_len, stray, declared, upto;
      bit overrun, big;
      flavor = $urandom_range(99);
      n_elem = $urandom_range(0, 3);
      for (int e = 0; e < n_elem; e++) begin
         elem.delete();
         repeat (NR_FIXED_LEN) elem.push_back(8'($urandom_range(255)));
         overrun = (flavor >= 60 && flavor < 68 && e == n_elem - 1);
         big = !overrun && ($urandom_range(19) == 0);
         n_sub = big ? 1 : $urandom_range(0, 3);
         for (int s = 0; s < n_sub; s++) begin
            sub_len = big ? $urandom_range(200, 238) : $urandom_range(0, 8);
            elem.push_back(8'($urandom_range(255)));
            elem.push_back(8'(sub_len));
            repeat (sub_len) elem.push_back(8'($urandom_range(255)));
         end
         if (overrun) begin
            // The length byte claims more than the element still holds.
            sub_len = $urandom_range(1, 6);
            elem.push_back(8'($urandom_range(255)));
            elem.push_back(8'($urandom_range(sub_len + 1, 255)));
            repeat (sub_len) elem.push_back(8'($urandom_range(255)));
         end else begin
            stray = $urandom_range(0, 2);
            repeat (stray) elem.push_back(8'($urandom_range(255)));
         end
         rpt.push_back(NR_ID);
         rpt.push_back(8'(elem.size()));
         foreach (elem[i]) rpt.push_back(elem[i]);
      end
      if ($urandom_range(9) < 3)
         repeat ($urandom_range(1, 14)) rpt.push_back(8'($urandom_range(255)));
      if (flavor >= 68 && flavor < 78 && rpt.size() > 0)
         rpt[$urandom_range(rpt.size() - 1)] = 8'($urandom_range(255));
      declared = rpt.size();
      upto = rpt.size();
      if (flavor >= 78 && flavor < 86) begin
         declared = declared - 3 + int'($urandom_range(0, 6));
         if (declared < 0) declared = 0;
      end else if (flavor >= 86 && flavor < 94) begin
         upto = $urandom_range(0, rpt.size());
         if ($urandom_range(1) == 1) declared = $urandom_range(2048, 4095);
      end
      send_item(MODE_START, 8'($urandom_range(255)), REPORT_LEN_W'(declared));
      for (int i = 0; i < upto; i++)
         send_item(MODE_DATA, rpt[i], REPORT_LEN_W'($urandom_range(4095)));
      if (flavor >= 94)
         repeat ($urandom_range(1, 4))
            send_item(MODE_DATA, 8'($urandom_range(255)), REPORT_LEN_W'($urandom_range(4095)));
   endtask

   task automatic run_reports(input int budget);
      int target;
      target = working_items + budget;
      while (working_items < target) send_report();
   endtask

   task automatic send_min_report(input logic [7:0] fixed[NR_FIXED_LEN]);
      send_item(MODE_START, 8'($urandom_range(255)), REPORT_LEN_W'(NR_MIN_REMAIN));
      send_item(MODE_DATA, NR_ID, REPORT_LEN_W'($urandom_range(4095)));
      send_item(MODE_DATA, 8'(NR_FIXED_LEN), REPORT_LEN_W'($urandom_range(4095)));
      foreach (fixed[i]) send_item(MODE_DATA, fixed[i], REPORT_LEN_W'($urandom_range(4095)));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_cases();
      logic [7:0] fixed[NR_FIXED_LEN] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE,
                                          8'h78, 8'h56, 8'h34, 8'h12, 8'hFF, 8'h00, 8'h80};
      set_idling(0, 0);
      send_item(MODE_START, 8'hFF, 12'd0);
      // Byte with no report open.
      send_item(MODE_DATA, 8'hFF, 12'hFFF);
      // Longest report, abandoned by a new start after the id byte.
      send_item(MODE_START, 8'h00, 12'hFFF);
      send_item(MODE_DATA, NR_ID, 12'h000);
      // Short report: skipped, then ends cleanly on its last byte.
      send_item(MODE_START, 8'h00, 12'd3);
      send_item(MODE_DATA, 8'h00, 12'h000);
      send_item(MODE_DATA, 8'hFF, 12'hFFF);
      send_item(MODE_DATA, NR_ID, 12'h000);
      send_item(MODE_START, 8'h00, 12'd20);
      send_item(MODE_DATA, 8'h00, 12'h000);
      send_item(MODE_START, 8'h00, 12'd20);
      send_item(MODE_DATA, NR_ID, 12'h000);
      send_item(MODE_DATA, 8'(NR_FIXED_LEN - 1), 12'h000);
      send_item(MODE_START, 8'h00, 12'd16);
      send_item(MODE_DATA, NR_ID, 12'h000);
      send_item(MODE_DATA, 8'd15, 12'h000);
      // Element that fills the report: record and end on one byte.
      send_min_report(fixed);
   endtask

   task automatic test_free_flow();
      set_idling(0, 0);
      run_reports(PHASE_ITEMS);
   endtask

   task automatic test_sender_gaps();
      set_idling(67, 0);
      run_reports(PHASE_ITEMS);
   endtask

   task automatic test_receiver_stalls();
      set_idling(0, 67);
      run_reports(PHASE_ITEMS);
   endtask

   task automatic test_both_gaps();
      set_idling(19, 19);
      run_reports(PHASE_ITEMS);
   endtask

   task automatic test_full_queue();
      logic [7:0] fixed[NR_FIXED_LEN];
      set_idling(0, 0);
      pressure_on <= 1'b1;
      repeat (3) begin
         repeat (10) send_item(MODE_START, 8'($urandom_range(255)), 12'd0);
         foreach (fixed[i]) fixed[i] = 8'($urandom_range(255));
         send_min_report(fixed);
      end
      while (hold_count < HOLD_CYCLES) @(posedge clock);
      pressure_on <= 1'b0;
   endtask

   initial begin
      int waited;
      int leftover;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_free_flow();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_gaps();
      test_full_queue();
      set_idling(0, 0);
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      leftover = pending_results.size();
      if (leftover != 0) $display("tb: %0d expected results never arrived", leftover);
      $display("tb: %0d transactions in (%0d parsed), %0d records and %0d status words matched",
               items_sent, working_items, records_checked, statuses_checked);
      $display("tb: phases ran free, with sender gaps, receiver stalls, both, and a full queue");
      if (fail_count == 0 && leftover == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
